// ===== sv/qvpid_pkg.sv =====
// ----------------------------------------------------------------------------
// qvpid_pkg
// Shared widths, constants and types of the quadrature velocity PID block.
// ----------------------------------------------------------------------------
package qvpid_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int DELTA_W     = 18;
  localparam int CMP_W       = (COUNT_WIDTH > DELTA_W) ? COUNT_WIDTH : DELTA_W;
  localparam int DELTA_CAP   = 65536;

  localparam int VEL_W    = 16;
  localparam int ERR_W    = 17;
  localparam int DIFF_W   = 18;
  localparam int INTEG_W  = 32;
  localparam int SUM_W    = 34;
  localparam int LIM_W    = 31;
  localparam int MA_W     = 33;
  localparam int MB_W     = 17;
  localparam int ACC_W    = 50;
  localparam int EFF_W    = 16;
  localparam int MAG_W    = 15;
  localparam int DUTY_W   = 20;
  localparam int DPROD_W  = 35;

  localparam int EFFORT_ONE = 16384;
  localparam int DUTY_FULL  = 1000000;
  localparam int INT_SHIFT  = 8;
  localparam int PD_SHIFT   = 8;
  localparam int EFF_SHIFT  = 10;
  localparam int DUTY_SHIFT = 14;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [VEL_W-1:0]          target;
    logic signed [DELTA_W-1:0] delta;
  } tick_t;

  typedef struct packed {
    logic             motor_reversed;
    logic [15:0]      velocity_scale;
    logic [15:0]      integ_period;
    logic [15:0]      gain_p;
    logic [15:0]      gain_i;
    logic [15:0]      gain_d;
    logic [LIM_W-1:0] integral_limit;
  } cfg_t;

endpackage

// ===== sv/qvpid_front.sv =====
// ----------------------------------------------------------------------------
// qvpid_front
// Takes input beats, tracks the 2x quadrature count and queues control ticks
// with the capped count change since the previous tick.
// ----------------------------------------------------------------------------
module qvpid_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [qvpid_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  output logic                             push,
  output qvpid_pkg::tick_t                 push_data,
  input  logic                             full
);

  localparam logic CMD_TICK = 1'b1;
  localparam logic CHAN_B   = 1'b1;

  logic [qvpid_pkg::COUNT_WIDTH-1:0]   edge_count_r;
  logic [qvpid_pkg::COUNT_WIDTH-1:0]   last_count_r;
  logic                                b_level_r;
  logic                                accept;
  logic                                edge_channel;
  logic                                edge_level;
  logic                                up;
  logic [qvpid_pkg::COUNT_WIDTH-1:0]   diff;
  logic signed [qvpid_pkg::CMP_W-1:0]  diff_ext;
  logic signed [qvpid_pkg::CMP_W-1:0]  cap_hi;
  logic signed [qvpid_pkg::CMP_W-1:0]  cap_lo;
  logic signed [qvpid_pkg::DELTA_W-1:0] delta;

  assign in_tready    = !full;
  assign accept       = in_tvalid && in_tready;
  assign edge_channel = in_tdata[0];
  assign edge_level   = in_tdata[1];
  assign up           = edge_level ? !b_level_r : b_level_r;

  // count change read as signed, magnitude capped
  assign diff     = edge_count_r - last_count_r;
  assign diff_ext = qvpid_pkg::CMP_W'($signed(diff));
  assign cap_hi   = qvpid_pkg::CMP_W'(qvpid_pkg::DELTA_CAP);
  assign cap_lo   = qvpid_pkg::CMP_W'(-qvpid_pkg::DELTA_CAP);

  always_comb begin
    if (diff_ext > cap_hi) begin
      delta = qvpid_pkg::DELTA_W'(qvpid_pkg::DELTA_CAP);
    end else if (diff_ext < cap_lo) begin
      delta = qvpid_pkg::DELTA_W'(-qvpid_pkg::DELTA_CAP);
    end else begin
      delta = qvpid_pkg::DELTA_W'(diff_ext);
    end
  end

  assign push             = accept && (in_tuser == CMD_TICK);
  assign push_data.target = in_tdata[2 +: qvpid_pkg::VEL_W];
  assign push_data.delta  = delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_count_r <= '0;
      last_count_r <= '0;
      b_level_r    <= 1'b0;
    end else if (accept) begin
      if (in_tuser == CMD_TICK) begin
        last_count_r <= edge_count_r;
      end else if (edge_channel == CHAN_B) begin
        b_level_r <= edge_level;
      end else if (up) begin
        edge_count_r <= edge_count_r + qvpid_pkg::COUNT_WIDTH'(1);
      end else begin
        edge_count_r <= edge_count_r - qvpid_pkg::COUNT_WIDTH'(1);
      end
    end
  end

endmodule

// ===== sv/qvpid_fifo.sv =====
// ----------------------------------------------------------------------------
// qvpid_fifo
// Two-entry queue of control ticks between the front and the PID sequencer.
// ----------------------------------------------------------------------------
module qvpid_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qvpid_pkg::tick_t push_data,
  input  logic             pop,
  output qvpid_pkg::tick_t pop_data,
  output logic             full,
  output logic             empty
);

  qvpid_pkg::tick_t mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ===== sv/qvpid_back.sv =====
// ----------------------------------------------------------------------------
// qvpid_back
// PID sequencer: one shared multiplier steps a tick through velocity,
// integrator, effort and duty, then loads the result register.
// ----------------------------------------------------------------------------
module qvpid_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qvpid_pkg::cfg_t                   cfg,
  input  logic                              empty,
  input  qvpid_pkg::tick_t                  pop_data,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [qvpid_pkg::OUT_DATA_W-1:0]  out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_VEL, S_SAT, S_ERR, S_MI, S_INT, S_MD, S_MG, S_ACC, S_EFF, S_DUTY
  } state_t;

  localparam int VEL_MAX = (1 << (qvpid_pkg::VEL_W - 1)) - 1;
  localparam int VEL_MIN = -(1 << (qvpid_pkg::VEL_W - 1));

  state_t                                state_r;
  logic                                  out_valid_r;
  logic [qvpid_pkg::VEL_W-1:0]           target_r;
  logic signed [qvpid_pkg::DELTA_W-1:0]  delta_r;
  logic signed [qvpid_pkg::ACC_W-1:0]    prod_r;
  logic signed [qvpid_pkg::ACC_W-1:0]    acc_r;
  logic signed [qvpid_pkg::VEL_W-1:0]    vel_r;
  logic signed [qvpid_pkg::ERR_W-1:0]    err_r;
  logic signed [qvpid_pkg::DIFF_W-1:0]   diff_r;
  logic signed [qvpid_pkg::INTEG_W-1:0]  integral_r;
  logic signed [qvpid_pkg::ERR_W-1:0]    prev_err_r;
  logic signed [qvpid_pkg::EFF_W-1:0]    effort_r;
  logic                                  dir_r;
  logic [qvpid_pkg::MAG_W-1:0]           mag_r;
  logic signed [qvpid_pkg::VEL_W-1:0]    res_vel_r;
  logic signed [qvpid_pkg::EFF_W-1:0]    res_effort_r;
  logic                                  res_dir_r;
  logic [qvpid_pkg::DUTY_W-1:0]          res_duty_r;

  logic signed [qvpid_pkg::MA_W-1:0]     mul_a;
  logic signed [qvpid_pkg::MB_W-1:0]     mul_b;
  logic signed [qvpid_pkg::ACC_W-1:0]    mul_p;
  logic signed [qvpid_pkg::ACC_W-1:0]    vel_signed;
  logic signed [qvpid_pkg::VEL_W-1:0]    vel_sat;
  logic signed [qvpid_pkg::ERR_W-1:0]    err;
  logic signed [qvpid_pkg::SUM_W-1:0]    integ_sum;
  logic signed [qvpid_pkg::SUM_W-1:0]    lim_pos;
  logic signed [qvpid_pkg::SUM_W-1:0]    lim_neg;
  logic signed [qvpid_pkg::INTEG_W-1:0]  integ_new;
  logic signed [qvpid_pkg::ACC_W-1:0]    acc_sh;
  logic signed [qvpid_pkg::EFF_W-1:0]    effort;
  logic signed [qvpid_pkg::EFF_W-1:0]    effort_dir;
  logic [qvpid_pkg::DPROD_W-1:0]         dprod;
  logic [qvpid_pkg::DUTY_W-1:0]          frac;
  logic [qvpid_pkg::DUTY_W-1:0]          duty;
  logic                                  out_free;

  // shared multiplier operands
  always_comb begin
    case (state_r)
      S_VEL: begin
        mul_a = qvpid_pkg::MA_W'(delta_r);
        mul_b = $signed({1'b0, cfg.velocity_scale});
      end
      S_MI: begin
        mul_a = qvpid_pkg::MA_W'(err_r);
        mul_b = $signed({1'b0, cfg.integ_period});
      end
      S_INT: begin
        mul_a = qvpid_pkg::MA_W'(err_r);
        mul_b = $signed({1'b0, cfg.gain_p});
      end
      S_MD: begin
        mul_a = qvpid_pkg::MA_W'(diff_r);
        mul_b = $signed({1'b0, cfg.gain_d});
      end
      S_MG: begin
        mul_a = qvpid_pkg::MA_W'(integral_r);
        mul_b = $signed({1'b0, cfg.gain_i});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // velocity: reverse then saturate
  assign vel_signed = cfg.motor_reversed ? -prod_r : prod_r;
  always_comb begin
    if (vel_signed > qvpid_pkg::ACC_W'(VEL_MAX)) begin
      vel_sat = qvpid_pkg::VEL_W'(VEL_MAX);
    end else if (vel_signed < qvpid_pkg::ACC_W'(VEL_MIN)) begin
      vel_sat = qvpid_pkg::VEL_W'(VEL_MIN);
    end else begin
      vel_sat = qvpid_pkg::VEL_W'(vel_signed);
    end
  end

  assign err = qvpid_pkg::ERR_W'($signed(target_r)) - qvpid_pkg::ERR_W'(vel_r);

  // integrator: arithmetic shift is the floor shift
  assign integ_sum = qvpid_pkg::SUM_W'(integral_r)
                   + qvpid_pkg::SUM_W'(prod_r >>> qvpid_pkg::INT_SHIFT);
  assign lim_pos   = $signed(qvpid_pkg::SUM_W'(cfg.integral_limit));
  assign lim_neg   = -lim_pos;
  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_new = qvpid_pkg::INTEG_W'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_new = qvpid_pkg::INTEG_W'(lim_neg);
    end else begin
      integ_new = qvpid_pkg::INTEG_W'(integ_sum);
    end
  end

  assign acc_sh = acc_r >>> qvpid_pkg::EFF_SHIFT;
  always_comb begin
    if (target_r == '0) begin
      effort = '0;
    end else if (acc_sh > qvpid_pkg::ACC_W'(qvpid_pkg::EFFORT_ONE)) begin
      effort = qvpid_pkg::EFF_W'(qvpid_pkg::EFFORT_ONE);
    end else if (acc_sh < qvpid_pkg::ACC_W'(-qvpid_pkg::EFFORT_ONE)) begin
      effort = qvpid_pkg::EFF_W'(-qvpid_pkg::EFFORT_ONE);
    end else begin
      effort = qvpid_pkg::EFF_W'(acc_sh);
    end
  end
  assign effort_dir = cfg.motor_reversed ? -effort : effort;

  // |e| * 1000000 / 16384, truncated
  assign dprod = qvpid_pkg::DPROD_W'(mag_r) * qvpid_pkg::DPROD_W'(qvpid_pkg::DUTY_FULL);
  assign frac  = dprod[qvpid_pkg::DUTY_SHIFT +: qvpid_pkg::DUTY_W];
  assign duty  = dir_r ? (qvpid_pkg::DUTY_W'(qvpid_pkg::DUTY_FULL) - frac) : frac;

  assign out_free   = !out_valid_r || out_tready;
  assign pop        = (state_r == S_IDLE) && !empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_duty_r, res_dir_r, res_effort_r, res_vel_r};

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      prev_err_r  <= '0;
    end else begin
      // in the duty step a leaving beat is replaced by the new one below
      if (out_valid_r && out_tready && (state_r != S_DUTY)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!empty) begin
            target_r <= pop_data.target;
            delta_r  <= pop_data.delta;
            state_r  <= S_VEL;
          end
        end
        S_VEL: state_r <= S_SAT;
        S_SAT: begin
          vel_r   <= vel_sat;
          state_r <= S_ERR;
        end
        S_ERR: begin
          err_r   <= err;
          diff_r  <= qvpid_pkg::DIFF_W'(err) - qvpid_pkg::DIFF_W'(prev_err_r);
          state_r <= S_MI;
        end
        S_MI: state_r <= S_INT;
        S_INT: begin
          integral_r <= integ_new;
          state_r    <= S_MD;
        end
        S_MD: begin
          acc_r   <= prod_r <<< qvpid_pkg::PD_SHIFT;
          state_r <= S_MG;
        end
        S_MG: begin
          acc_r   <= acc_r + (prod_r <<< qvpid_pkg::PD_SHIFT);
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + prod_r;
          state_r <= S_EFF;
        end
        S_EFF: begin
          effort_r <= effort;
          dir_r    <= (effort_dir > 0);
          mag_r    <= (effort_dir < 0) ? qvpid_pkg::MAG_W'(-effort_dir)
                                       : qvpid_pkg::MAG_W'(effort_dir);
          // zero target clears the loop memory
          if (target_r == '0) begin
            integral_r <= '0;
            prev_err_r <= '0;
          end else begin
            prev_err_r <= err_r;
          end
          state_r <= S_DUTY;
        end
        S_DUTY: begin
          if (out_free) begin
            res_vel_r    <= vel_r;
            res_effort_r <= effort_r;
            res_dir_r    <= dir_r;
            res_duty_r   <= duty;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_effort_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_effort_r <= qvpid_pkg::EFF_W'(qvpid_pkg::EFFORT_ONE)) &&
                    (res_effort_r >= qvpid_pkg::EFF_W'(-qvpid_pkg::EFFORT_ONE)))
    else $error("drive effort out of range");
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_duty_r <= qvpid_pkg::DUTY_W'(qvpid_pkg::DUTY_FULL)))
    else $error("pwm duty above full scale");
  a_zero_effort: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_effort_r == '0) |-> (!res_dir_r && res_duty_r == '0))
    else $error("zero effort must give zero duty, reverse pin");
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUTY && out_valid_r && !out_tready) |=> (state_r == S_DUTY))
    else $error("sequencer left duty step while result stalled");
`endif

endmodule

// ===== sv/quadrature_velocity_pid_top.sv =====
// ----------------------------------------------------------------------------
// quadrature_velocity_pid_top
// 2x quadrature encoder counter with a fixed-point velocity PID loop.
//
//   channel | ports   | beat                 | payload
//   --------+---------+----------------------+---------------------------------
//   input   | in_*    | tvalid & tready      | tuser cmd, tdata edge / target
//   result  | out_*   | tvalid & tready      | tdata velocity, effort, dir, duty
//   config  | cfg_*   | psel&penable&pwrite  | 7 registers at 4*index
//
// encoder edge beats are taken one per cycle while the tick queue has room
// and give no result. a control tick steps the sequencer from velocity to duty,
// using the shared 33x17 multiplier five times; ticks queue two deep ahead of it.
// rst_n is synchronous; registers return to their defaults, counts to zero.
// in_tready drops only while the tick queue is full; a stalled result holds
// the sequencer at its last step.
// ----------------------------------------------------------------------------
module quadrature_velocity_pid_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // edge_channel, edge_level, target_velocity[15:0], pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // measured_velocity, drive_effort, motor_direction,
                                  // pwm_duty[19:0], pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] REG_MOTOR_REVERSED = 3'd0;
  localparam logic [2:0] REG_VELOCITY_SCALE = 3'd1;
  localparam logic [2:0] REG_INTEG_PERIOD   = 3'd2;
  localparam logic [2:0] REG_GAIN_P         = 3'd3;
  localparam logic [2:0] REG_GAIN_I         = 3'd4;
  localparam logic [2:0] REG_GAIN_D         = 3'd5;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;

  qvpid_pkg::cfg_t  cfg_r;
  qvpid_pkg::tick_t push_data;
  qvpid_pkg::tick_t pop_data;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic             cfg_write;
  logic [2:0]       reg_index;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_index  = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_reversed <= 1'b0;
      cfg_r.velocity_scale <= 16'd256;
      cfg_r.integ_period   <= 16'd655;
      cfg_r.gain_p         <= 16'd256;
      cfg_r.gain_i         <= 16'd0;
      cfg_r.gain_d         <= 16'd0;
      cfg_r.integral_limit <= 31'd65536;
    end else if (cfg_write) begin
      case (reg_index)
        REG_MOTOR_REVERSED: cfg_r.motor_reversed <= cfg_pwdata[0];
        REG_VELOCITY_SCALE: cfg_r.velocity_scale <= cfg_pwdata[15:0];
        REG_INTEG_PERIOD:   cfg_r.integ_period   <= cfg_pwdata[15:0];
        REG_GAIN_P:         cfg_r.gain_p         <= cfg_pwdata[15:0];
        REG_GAIN_I:         cfg_r.gain_i         <= cfg_pwdata[15:0];
        REG_GAIN_D:         cfg_r.gain_d         <= cfg_pwdata[15:0];
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_MOTOR_REVERSED: cfg_prdata = {31'd0, cfg_r.motor_reversed};
      REG_VELOCITY_SCALE: cfg_prdata = {16'd0, cfg_r.velocity_scale};
      REG_INTEG_PERIOD:   cfg_prdata = {16'd0, cfg_r.integ_period};
      REG_GAIN_P:         cfg_prdata = {16'd0, cfg_r.gain_p};
      REG_GAIN_I:         cfg_prdata = {16'd0, cfg_r.gain_i};
      REG_GAIN_D:         cfg_prdata = {16'd0, cfg_r.gain_d};
      REG_INTEGRAL_LIMIT: cfg_prdata = {1'b0, cfg_r.integral_limit};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  qvpid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  qvpid_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  qvpid_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .empty      (empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== verif/tb_quadrature_velocity_pid_top.sv =====
// ----------------------------------------------------------------------------
// tb_quadrature_velocity_pid_top
// Self-checking bench for the quadrature encoder velocity PID block: a short
// table of hand-picked beats followed by random phases of quadrature runs,
// encoder noise and control ticks under changing register settings. Every
// result beat is checked against a cycle-free loop model or a typed table row.
// ----------------------------------------------------------------------------
module tb_quadrature_velocity_pid_top;

  localparam bit CMD_EDGE = 1'b0;
  localparam bit CMD_TICK = 1'b1;
  localparam bit CH_A     = 1'b0;
  localparam bit CH_B     = 1'b1;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_WAIT  = 24;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 106;
  localparam int REPORT_LINES = 30;

  typedef enum logic [2:0] {
    REG_REVERSED, REG_VEL_SCALE, REG_INTEG_PERIOD, REG_GAIN_P,
    REG_GAIN_I, REG_GAIN_D, REG_INTEG_LIMIT, REG_UNUSED
  } cfg_reg_e;

  typedef struct {
    logic [15:0] vel;
    logic [15:0] eff;
    logic        dir;
    logic [19:0] duty;
  } ctrl_result_t;

  typedef struct {
    bit          cmd;
    bit          chan;
    bit          lvl;
    logic [15:0] tgt;
    bit          typed;
    logic [15:0] vel;
    logic [15:0] eff;
    bit          dir;
    logic [19:0] duty;
  } steer_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #1 clk = ~clk;

  quadrature_velocity_pid_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // model of the loop
  qvpid_pkg::cfg_t                    cfg_model;
  logic [qvpid_pkg::COUNT_WIDTH-1:0]  enc_count;
  logic [qvpid_pkg::COUNT_WIDTH-1:0]  count_at_tick;
  bit                                 b_seen;
  longint                             integ_acc;
  longint                             last_err;

  ctrl_result_t pending_results[$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           cycle_cnt = 0;

  // stimulus side pin levels and idling controls
  bit a_pin = 1'b0;
  bit b_pin = 1'b0;
  bit tx_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit hold_req = 1'b0;

  steer_row_t steer_rows[15] = '{
    '{CMD_TICK, CH_A, 1'b0, 16'h0000, 1'b1, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_EDGE, CH_A, 1'b1, 16'hFFFF, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_TICK, CH_B, 1'b1, 16'h0000, 1'b1, 16'd256, 16'd0,     1'b0, 20'd0},
    '{CMD_TICK, CH_A, 1'b0, 16'h7FFF, 1'b1, 16'd0,   16'd16384, 1'b1, 20'd0},
    '{CMD_TICK, CH_A, 1'b0, 16'h8000, 1'b1, 16'd0,   16'hC000,  1'b0, 20'd1000000},
    '{CMD_EDGE, CH_B, 1'b1, 16'h0000, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_EDGE, CH_A, 1'b0, 16'h0000, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_EDGE, CH_A, 1'b1, 16'h0000, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_EDGE, CH_A, 1'b0, 16'h0000, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_EDGE, CH_B, 1'b0, 16'h0000, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_EDGE, CH_A, 1'b0, 16'h8000, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_TICK, CH_B, 1'b0, 16'h0100, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_TICK, CH_A, 1'b1, 16'h0001, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_TICK, CH_B, 1'b1, 16'hFFFF, 1'b0, 16'd0,   16'd0,     1'b0, 20'd0},
    '{CMD_TICK, CH_A, 1'b0, 16'h0000, 1'b1, 16'd0,   16'd0,     1'b0, 20'd0}
  };

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic void apply_edge(bit chan, bit lvl);
    if (chan == CH_B) begin
      b_seen = lvl;
    end else if (lvl ? !b_seen : b_seen) begin
      enc_count = enc_count + 1'b1;
    end else begin
      enc_count = enc_count - 1'b1;
    end
  endfunction

  function automatic ctrl_result_t run_tick(logic [15:0] tgt_raw);
    ctrl_result_t                      res;
    logic [qvpid_pkg::COUNT_WIDTH-1:0] d;
    logic [qvpid_pkg::COUNT_WIDTH-1:0] mag;
    longint tgt, delta, vel, err, acc, eff, e, frac;
    tgt = longint'($signed(tgt_raw));
    d = enc_count - count_at_tick;
    // signed count change, magnitude capped at one full Q8.8 unit range
    if (d[qvpid_pkg::COUNT_WIDTH-1]) begin
      mag = -d;
      if (mag == 0 || mag > qvpid_pkg::DELTA_CAP) mag = qvpid_pkg::DELTA_CAP;
      delta = -longint'(mag);
    end else begin
      delta = (d > qvpid_pkg::DELTA_CAP) ? qvpid_pkg::DELTA_CAP : longint'(d);
    end
    vel = delta * longint'(cfg_model.velocity_scale);
    if (cfg_model.motor_reversed) vel = -vel;
    vel = clip(vel, -32768, 32767);
    count_at_tick = enc_count;

    err = tgt - vel;
    integ_acc = integ_acc + ((err * longint'(cfg_model.integ_period)) >>> 8);
    integ_acc = clip(integ_acc, -longint'(cfg_model.integral_limit),
                     longint'(cfg_model.integral_limit));
    acc = longint'(cfg_model.gain_p) * err * 256
        + longint'(cfg_model.gain_i) * integ_acc
        + longint'(cfg_model.gain_d) * (err - last_err) * 256;
    last_err = err;
    eff = clip(acc >>> 10, -qvpid_pkg::EFFORT_ONE, qvpid_pkg::EFFORT_ONE);

    if (tgt == 0) begin
      eff = 0;
      integ_acc = 0;
      last_err = 0;
    end

    e = cfg_model.motor_reversed ? -eff : eff;
    if (e <= 0) begin
      frac = (-e) * qvpid_pkg::DUTY_FULL / qvpid_pkg::EFFORT_ONE;
      res.dir = 1'b0;
      res.duty = frac[19:0];
    end else begin
      frac = e * qvpid_pkg::DUTY_FULL / qvpid_pkg::EFFORT_ONE;
      res.dir = 1'b1;
      res.duty = 20'(qvpid_pkg::DUTY_FULL - frac);
    end
    res.vel = vel[15:0];
    res.eff = eff[15:0];
    return res;
  endfunction

  task automatic note_mismatch(string what, longint got, longint want);
    if (mismatches < REPORT_LINES)
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
    mismatches++;
  endtask

  // result beats are checked in order against the oldest prediction
  always @(posedge clk) begin
    ctrl_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.vel  = out_tdata[15:0];
      got.eff  = out_tdata[31:16];
      got.dir  = out_tdata[32];
      got.duty = out_tdata[52:33];
      if (pending_results.size() == 0) begin
        note_mismatch("beat with nothing pending", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.vel !== want.vel)
          note_mismatch("measured_velocity", $signed(got.vel), $signed(want.vel));
        if (got.eff !== want.eff)
          note_mismatch("drive_effort", $signed(got.eff), $signed(want.eff));
        if (got.dir !== want.dir)
          note_mismatch("motor_direction", got.dir, want.dir);
        if (got.duty !== want.duty)
          note_mismatch("pwm_duty", got.duty, want.duty);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result sink: random stalls, one long hold-off on request
  initial begin : result_sink
    int pick;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (sink_calm || pick < 80) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (pick < 97 ? $urandom_range(0, 2) : $urandom_range(8, 40)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic drive_beat(input bit cmd, input bit chan, input bit lvl,
                            input logic [15:0] tgt, input bit typed,
                            input ctrl_result_t typed_res);
    int           gap;
    ctrl_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, tgt, lvl, chan};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_TICK) begin
      res = run_tick(tgt);
      pending_results.push_back(typed ? typed_res : res);
    end else begin
      apply_edge(chan, lvl);
    end
  endtask

  task automatic send_edge(bit chan, bit lvl);
    ctrl_result_t none;
    none = '{default: '0};
    drive_beat(CMD_EDGE, chan, lvl, 16'($urandom), 1'b0, none);
  endtask

  task automatic send_tick(logic [15:0] tgt);
    ctrl_result_t none;
    none = '{default: '0};
    drive_beat(CMD_TICK, 1'($urandom), 1'($urandom), tgt, 1'b0, none);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [31:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_REVERSED:     cfg_model.motor_reversed = wdata[0];
      REG_VEL_SCALE:    cfg_model.velocity_scale = wdata[15:0];
      REG_INTEG_PERIOD: cfg_model.integ_period   = wdata[15:0];
      REG_GAIN_P:       cfg_model.gain_p         = wdata[15:0];
      REG_GAIN_I:       cfg_model.gain_i         = wdata[15:0];
      REG_GAIN_D:       cfg_model.gain_d         = wdata[15:0];
      REG_INTEG_LIMIT:  cfg_model.integral_limit = wdata[30:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_u16(int typ_max);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, typ_max));
  endfunction

  task automatic set_phase_config(int phase);
    logic [31:0] vals[7];
    int          widths[7];
    int          r;
    widths = '{1, 16, 16, 16, 16, 16, 31};
    if (phase == 1) begin
      vals = '{32'h1, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h7FFF_FFFF};
    end else if (phase == 2) begin
      vals = '{default: 32'h0};
    end else begin
      vals[REG_REVERSED]     = $urandom_range(0, 1);
      vals[REG_VEL_SCALE]    = pick_u16(1024);
      vals[REG_INTEG_PERIOD] = pick_u16(4096);
      vals[REG_GAIN_P]       = pick_u16(2048);
      vals[REG_GAIN_I]       = pick_u16(1024);
      vals[REG_GAIN_D]       = pick_u16(1024);
      r = $urandom_range(0, 9);
      vals[REG_INTEG_LIMIT]  = (r == 0) ? 32'h0 :
                               (r == 1) ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 24);
    end
    for (int i = 0; i < 7; i++) begin
      // junk above the register width must be dropped
      if ($urandom_range(0, 3) == 0)
        vals[i] = vals[i] | ($urandom & ~((32'h1 << widths[i]) - 1));
      cfg_write(cfg_reg_e'(i), vals[i]);
    end
    if (phase == 1 || $urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, $urandom);
  endtask

  function automatic logic [15:0] pick_target();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 16'h0000;
    if (r == 2) return 16'h7FFF;
    if (r == 3) return 16'h8000;
    if (r < 7) return 16'($urandom);
    return 16'($urandom_range(0, 8191) - 4096);
  endfunction

  // runs of clean quadrature steps in one direction, some noise, then a tick
  task automatic run_random_phase(int n_items);
    int sent;
    int run_len;
    bit fwd;
    bit chan;
    sent = 0;
    while (sent < n_items) begin
      run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                             : $urandom_range(0, 12);
      fwd = $urandom_range(0, 1);
      repeat (run_len) begin
        if ($urandom_range(0, 9) < 8) begin
          // forward order is 00 -> 10 -> 11 -> 01, reverse walks it back
          chan = fwd ? (a_pin != b_pin) : (a_pin == b_pin);
          if (chan == CH_A) a_pin = !a_pin;
          else b_pin = !b_pin;
          send_edge(chan, chan ? b_pin : a_pin);
        end else begin
          chan = $urandom_range(0, 1);
          if (chan == CH_A) a_pin = $urandom_range(0, 1);
          else b_pin = $urandom_range(0, 1);
          send_edge(chan, chan ? b_pin : a_pin);
        end
        sent++;
      end
      send_tick(pick_target());
      sent++;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  initial begin
    ctrl_result_t typed_res;
    cfg_model = '{motor_reversed: 1'b0, velocity_scale: 16'd256, integ_period: 16'd655,
                  gain_p: 16'd256, gain_i: 16'd0, gain_d: 16'd0,
                  integral_limit: 31'd65536};
    enc_count = '0;
    count_at_tick = '0;
    b_seen = 1'b0;
    integ_acc = 0;
    last_err = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steer_rows[i]) begin
      typed_res.vel  = steer_rows[i].vel;
      typed_res.eff  = steer_rows[i].eff;
      typed_res.dir  = steer_rows[i].dir;
      typed_res.duty = steer_rows[i].duty;
      drive_beat(steer_rows[i].cmd, steer_rows[i].chan, steer_rows[i].lvl,
                 steer_rows[i].tgt, steer_rows[i].typed, typed_res);
    end
    // directed beats leave A low and B low
    a_pin = 1'b0;
    b_pin = 1'b0;
    settle();

    for (int p = 1; p <= PHASES; p++) begin
      set_phase_config(p);
      tx_calm   = (p % 4 == 3);
      sink_calm = (p % 5 == 2);
      if (p == 4) hold_req = 1'b1;
      run_random_phase(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
